FILE: rtl/tsq_pkg.sv
// tsq_pkg: shared types and codes of the timestamp ordered request queue
// depends on nothing; imported by timestamp_ordered_request_queue_top and the testbench
package tsq_pkg;

    localparam int ID_W     = 4;
    localparam int STAMP_W  = 15;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int ENTRY_W  = ID_W + STAMP_W;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

FILE: rtl/tsq_ram.sv
// tsq_ram: generic simple dual port ram (separate write and read address), one write and one registered read per cycle
// no dependencies
module tsq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/timestamp_ordered_request_queue_top.sv
// timestamp_ordered_request_queue_top: sorted request queue with delete by id
// depends on tsq_pkg and tsq_ram
//
// channel   dir  handshake                        payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser opcode, tdata id and stamp
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata status, head, count
//
// the compare logic and one ram are reused; each table entry visited passes a read and a check state
// an insert into a full table goes straight to the answer; an insert walks up from the tail, moving
// later or equal entries, and a delete walks the whole table; ready returns with the answer
// reset clears the count and the output valid; the table needs no clearing
// a new word is taken while the last result waits; the sequencer holds before
// its own result until the output register is free
module timestamp_ordered_request_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [0:0]  i_s_axis_tuser,   // [0] opcode
    input  logic [23:0] i_s_axis_tdata,   // [3:0] proc_id, [18:4] stamp, [23:19] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [1:0] status, [2] head_valid, [6:3] head_id,
                                          // [21:7] head_stamp, [26:22] count, [31:27] zero
);
    import tsq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int KW = $clog2(DEPTH + 1);
    localparam logic [KW-1:0] FULL_COUNT = KW'(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_DONE} t_state;

    t_state           r_state, n_state;
    t_opcode          r_op, n_op;
    t_entry           r_new, n_new;
    t_entry           r_head, n_head;
    t_status          r_status, n_status;
    logic [KW-1:0]    r_count, n_count;
    logic [KW-1:0]    r_k, n_k;
    logic             r_found, n_found;
    logic             r_ovalid, n_ovalid;
    logic [31:0]      r_odata, n_odata;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_entry           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    t_entry           ram_rdata;
    logic [KW-1:0]    k_dec;
    logic             stamp_ge;
    logic             id_eq;
    logic             head_valid;

    tsq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign k_dec      = r_k - 1'b1;
    // the compare logic: the stamp compare serves the insert walk, the id compare the delete walk
    assign stamp_ge   = (ram_rdata.stamp >= r_new.stamp);
    assign id_eq      = (ram_rdata.id == r_new.id);
    assign head_valid = (r_count != '0);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_new     = r_new;
        n_head    = r_head;
        n_status  = r_status;
        n_count   = r_count;
        n_k       = r_k;
        n_found   = r_found;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = r_k[AW-1:0];
        ram_wdata = r_new;
        ram_raddr = r_k[AW-1:0];

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op       = t_opcode'(i_s_axis_tuser[0]);
                    n_new.id   = i_s_axis_tdata[3:0];
                    n_new.stamp = i_s_axis_tdata[18:4];
                    n_found    = 1'b0;
                    n_status   = ST_DONE;
                    if (t_opcode'(i_s_axis_tuser[0]) == OP_INSERT) begin
                        n_k = r_count;
                        if (r_count >= FULL_COUNT) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_k     = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_op == OP_INSERT) begin
                    if (r_k == '0) begin
                        // new word becomes the head
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        n_head    = r_new;
                        n_count   = r_count + 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        ram_raddr = k_dec[AW-1:0];
                        n_state   = S_CHK;
                    end
                end else begin
                    if (r_k == r_count) begin
                        if (r_found) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (r_op == OP_INSERT) begin
                    ram_we = 1'b1;
                    if (stamp_ge) begin
                        // later or equal stamp moves one place toward the tail
                        ram_wdata = ram_rdata;
                        n_k       = k_dec;
                        n_state   = S_RD;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = k_dec[AW-1:0];
                        ram_wdata = ram_rdata;
                        if (k_dec == '0) begin
                            n_head = ram_rdata;
                        end
                    end else if (id_eq) begin
                        n_found = 1'b1;
                    end
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid       = 1'b1;
                    n_odata        = '0;
                    n_odata[1:0]   = r_status;
                    n_odata[2]     = head_valid;
                    n_odata[6:3]   = head_valid ? r_head.id : '0;
                    n_odata[21:7]  = head_valid ? r_head.stamp : '0;
                    n_odata[26:22] = COUNT_W'(r_count);
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
        end
        r_op     <= n_op;
        r_new    <= n_new;
        r_head   <= n_head;
        r_status <= n_status;
        r_k      <= n_k;
        r_odata  <= n_odata;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
             || r_count == $past(r_count) - 1'b1))
        else $error("entry count moved by more than one");

    a_count_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RD && r_state != S_CHK) |=> r_count == $past(r_count))
        else $error("entry count changed outside a table walk");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_RD || r_state == S_CHK))
        else $error("table written while idle");

    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || i_m_axis_tready))
            |=> o_m_axis_tdata[2] == (o_m_axis_tdata[26:22] != '0) || DEPTH > 31)
        else $error("head valid disagrees with count");

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for timestamp_ordered_request_queue_top
// depends on tsq_pkg and the rtl; a built-in sorted queue predicts every answer word
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 4000;
    localparam int DRAIN_WAIT = 100;

    typedef struct {
        t_opcode            op;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } t_word;

    typedef struct {
        t_status            status;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [STAMP_W-1:0] head_stamp;
        logic [COUNT_W-1:0] count;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [0:0]  i_s_axis_tuser = '0;   // [0] opcode
    logic [23:0] i_s_axis_tdata = '0;   // [3:0] proc_id, [18:4] stamp, [23:19] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [1:0] status, [2] head_valid, [6:3] head_id,
                                        // [21:7] head_stamp, [26:22] count

    timestamp_ordered_request_queue_top #(.DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    t_word   req_words[$];
    t_answer answers_due[$];
    int      live_ids[$];       // ids the stimulus believes are queued
    t_entry  sorted_table[DEPTH];
    int      sorted_count = 0;
    int      n_taken = 0;
    int      n_err = 0;
    int      stall_cycles = 0;

    // sorted queue predictor, one answer per request
    function automatic t_answer sorted_queue_step(t_word w);
        t_answer a;
        int      pos;
        a.status = ST_DONE;
        pos = 0;
        if (w.op == OP_INSERT) begin
            if (sorted_count >= DEPTH) begin
                a.status = ST_FULL;
            end else begin
                // ties go in front of equal stamps
                while (pos < sorted_count && sorted_table[pos].stamp < w.stamp) pos++;
                for (int k = sorted_count; k > pos; k--) sorted_table[k] = sorted_table[k-1];
                sorted_table[pos].id    = w.id;
                sorted_table[pos].stamp = w.stamp;
                sorted_count++;
            end
        end else begin
            while (pos < sorted_count && sorted_table[pos].id != w.id) pos++;
            if (pos >= sorted_count) begin
                a.status = ST_NOT_FOUND;
            end else begin
                for (int k = pos; k + 1 < sorted_count; k++) sorted_table[k] = sorted_table[k+1];
                sorted_count--;
            end
        end
        a.head_valid = (sorted_count > 0);
        a.head_id    = (sorted_count > 0) ? sorted_table[0].id : '0;
        a.head_stamp = (sorted_count > 0) ? sorted_table[0].stamp : '0;
        a.count      = COUNT_W'(sorted_count);
        return a;
    endfunction

    function automatic t_word mk_word(t_opcode op, int id, int stamp);
        t_word w;
        w.op    = op;
        w.id    = ID_W'(id);
        w.stamp = STAMP_W'(stamp);
        return w;
    endfunction

    // queue a request and keep the id bookkeeping used to aim deletes
    function automatic void push_request(t_word w);
        int hit[$];
        req_words.push_back(w);
        if (w.op == OP_INSERT) begin
            if (live_ids.size() < DEPTH) live_ids.push_back(w.id);
        end else begin
            hit = live_ids.find_first_index(x) with (x == w.id);
            if (hit.size() > 0) live_ids.delete(hit[0]);
        end
    endfunction

    // no idling on either side for a stretch in the middle of the run
    function automatic int idle_pct();
        return (n_taken >= 900 && n_taken < 1200) ? 0 : 35;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (req_words.size() > 0 && $urandom_range(0, 99) >= idle_pct()) begin
                w = req_words.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= w.op;
                i_s_axis_tdata  <= {5'b0, w.stamp, w.id};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // answer sink back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= idle_pct());
    end

    // monitor: check answers first, then predict for the request taken this edge
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        t_word   w;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.status     = t_status'(o_m_axis_tdata[1:0]);
                got.head_valid = o_m_axis_tdata[2];
                got.head_id    = o_m_axis_tdata[6:3];
                got.head_stamp = o_m_axis_tdata[21:7];
                got.count      = o_m_axis_tdata[26:22];
                if (answers_due.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected answer word: tdata=%h", o_m_axis_tdata);
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status || got.head_valid !== want.head_valid ||
                        got.head_id !== want.head_id || got.head_stamp !== want.head_stamp ||
                        got.count !== want.count) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $write("mismatch: exp st=%0d hv=%0d id=%0d ts=%0d cnt=%0d",
                                   want.status, want.head_valid, want.head_id,
                                   want.head_stamp, want.count);
                            $display(" got st=%0d hv=%0d id=%0d ts=%0d cnt=%0d",
                                     got.status, got.head_valid, got.head_id,
                                     got.head_stamp, got.count);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                w.op    = t_opcode'(i_s_axis_tuser[0]);
                w.id    = i_s_axis_tdata[3:0];
                w.stamp = i_s_axis_tdata[18:4];
                answers_due.push_back(sorted_queue_step(w));
                n_taken <= n_taken + 1;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("timestamp_ordered_request_queue_top verification failed");
            $finish;
        end
    end

    initial begin
        int     roll;
        int     ins_pct;
        int     stamp;
        int     last_stamp;
        int     id;
        t_word  w;

        // directed: empty delete, extremes, head and tail ties, duplicates, full
        push_request(mk_word(OP_DELETE, 3, 0));
        push_request(mk_word(OP_INSERT, 15, 32767));
        push_request(mk_word(OP_INSERT, 0, 0));
        push_request(mk_word(OP_INSERT, 5, 0));
        push_request(mk_word(OP_INSERT, 9, 32767));
        push_request(mk_word(OP_INSERT, 0, 100));
        push_request(mk_word(OP_DELETE, 0, 32767));
        push_request(mk_word(OP_DELETE, 7, 0));
        for (int k = 0; k < 12; k++)
            push_request(mk_word(OP_INSERT, k, (k == 4) ? 100 : $urandom_range(1, 32766)));
        push_request(mk_word(OP_INSERT, 3, 77));
        push_request(mk_word(OP_DELETE, 5, 0));

        // random: fill, drain and balanced phases, deletes mostly aimed at queued ids
        last_stamp = 0;
        for (int k = 0; k < 1950; k++) begin
            case ((k / 64) % 3)
                0:       ins_pct = 80;
                1:       ins_pct = 25;
                default: ins_pct = 50;
            endcase
            roll = $urandom_range(0, 9);
            if (roll < 4)      stamp = $urandom_range(0, 32767);
            else if (roll < 7) stamp = $urandom_range(0, 15);
            else if (roll < 8) stamp = $urandom_range(32760, 32767);
            else if (roll < 9) stamp = $urandom_range(0, 1) ? 32767 : 0;
            else               stamp = last_stamp;
            last_stamp = stamp;
            if ($urandom_range(0, 99) < ins_pct) begin
                w = mk_word(OP_INSERT, $urandom_range(0, 15), stamp);
            end else begin
                if (live_ids.size() > 0 && $urandom_range(0, 99) < 80)
                    id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                else
                    id = $urandom_range(0, 15);
                w = mk_word(OP_DELETE, id, $urandom_range(0, 32767));
            end
            push_request(w);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_words.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_err == 0 && answers_due.size() == 0)
            $display("timestamp_ordered_request_queue_top verification clean");
        else
            $display("timestamp_ordered_request_queue_top verification failed");
        $finish;
    end

endmodule
